// ----- rtl/core/tbss_pkg.sv -----
package tbss_pkg;

  // Fixed formats of the sample path.
  localparam int SAMPLE_W = 24;
  localparam int WDATA_W  = 25;
  localparam int INDEX_W  = 3;

  // Interpolation tweak 0.0414213562 in Q0.24.
  localparam int TWEAK_Q24   = 694935;
  // Alias accumulator decay 0.9159655942 in Q0.24.
  localparam int DECAY_Q24   = 15367353;
  // Quarter turn pi/2 in Q2.30.
  localparam int HALFPI_Q30  = 1686629713;
  // Unity in the coefficient and threshold formats.
  localparam int UNITY_Q16   = 65536;
  localparam int UNITY_Q24   = 16777216;
  // Output trim in Q0.15.
  localparam int OUTPUT_TRIM = 32768;
  // Quotient bits of the clip phase division.
  localparam int DIV_STEPS   = 17;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    REG_LOWPASS_COEFF  = 3'd0,
    REG_GAIN_HIGH      = 3'd1,
    REG_GAIN_LOW       = 3'd2,
    REG_THRESHOLD_HIGH = 3'd3,
    REG_THRESHOLD_LOW  = 3'd4,
    REG_MIX_HIGH       = 3'd5,
    REG_MIX_LOW        = 3'd6,
    REG_MIX_DRY        = 3'd7
  } reg_idx_t;

  // Sequencer steps; the datapath performs the operation named by the step.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TWEAK,
    ST_MID,
    ST_DRY,
    ST_LP_MUL,
    ST_LP_ACC,
    ST_GL_MUL,
    ST_GL_RND,
    ST_CLIP_CHK,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_SIN_IDX,
    ST_SIN_RD,
    ST_SIN_MUL,
    ST_SIN_INT,
    ST_SCL_MUL,
    ST_SCL,
    ST_LOW_SAVE,
    ST_GH_RND,
    ST_MIX_L,
    ST_MIX_H,
    ST_MIX_OUT,
    ST_DEC_A,
    ST_DEC_B,
    ST_DEC_OM,
    ST_DEC_O,
    ST_TRIM,
    ST_OUT
  } ctrl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    ctrl_state_t step;
    logic        load;
    logic        band;
    logic        clip_high;
    logic        out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clip_active;
  } status_t;

  function automatic logic [63:0] mulq30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // Odd polynomial for sin(x * pi/2), x in Q2.30, result in Q0.24 capped at one.
  function automatic logic [24:0] sine_poly(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = mulq30(x, x);
    t = 64'd172272 - mulq30(x2, 64'd3864);
    t = 64'd5026996 - mulq30(x2, t);
    t = 64'd85569310 - mulq30(x2, t);
    t = 64'd693598668 - mulq30(x2, t);
    t = 64'(HALFPI_Q30) - mulq30(x2, t);
    s = (mulq30(x, t) + 64'd32) >> 6;
    if (s > 64'(UNITY_Q24)) s = 64'(UNITY_Q24);
    return s[24:0];
  endfunction

endpackage

// ----- rtl/core/tbss_in_if.sv -----
interface tbss_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbss_pkg::SAMPLE_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

// ----- rtl/core/tbss_out_if.sv -----
interface tbss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbss_pkg::SAMPLE_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

// ----- rtl/core/two_band_sine_saturator.sv -----
// Two-band sine saturator: one Q1.23 sample beat in, one Q1.23 sample beat out.
// Each sample runs through a sequencer that shares a single 42x26 multiplier,
// a quarter-wave sine table and a one-bit-per-cycle divider for the clip phase.
// Each band clip that enters its soft knee adds the divider, sine-table and scale
// steps to the sample. The next sample is accepted once the previous result is in
// the output register, even while that beat waits. Registers are written through
// wr_en, wr_index and wr_data; the user must write them only while the block idles,
// as the block itself does not enforce it.
module two_band_sine_saturator #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [tbss_pkg::INDEX_W-1:0] wr_index,
  input  logic [tbss_pkg::WDATA_W-1:0] wr_data,
  tbss_in_if.sink                      audio,
  tbss_out_if.source                   result
);

  tbss_pkg::cmd_t    cmd;
  tbss_pkg::status_t status;

  tbss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (audio.valid),
    .in_ready  (audio.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tbss_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_sample  (audio.in_sample),
    .out_sample (result.out_sample),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ----- rtl/core/tbss_ctrl.sv -----
module tbss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tbss_pkg::status_t status,
  output tbss_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(tbss_pkg::DIV_STEPS);

  tbss_pkg::ctrl_state_t state, state_next;
  logic                  band, band_next;
  logic                  clip_high, clip_high_next;
  logic [CNT_W-1:0]      count, count_next;
  logic                  out_valid_next;
  logic                  out_load;
  tbss_pkg::ctrl_state_t clip_ret;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tbss_pkg::ST_IDLE;
      band      <= 1'b0;
      clip_high <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      band      <= band_next;
      clip_high <= clip_high_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // The clip routine returns to the step after the band it serves.
  assign clip_ret = clip_high ? tbss_pkg::ST_MIX_L : tbss_pkg::ST_LOW_SAVE;
  assign in_ready = (state == tbss_pkg::ST_IDLE);
  assign out_load = (state == tbss_pkg::ST_OUT) && (!out_valid || out_ready);

  // Next step and commands.
  always_comb begin
    state_next     = state;
    band_next      = band;
    clip_high_next = clip_high;
    count_next     = count;
    unique case (state)
      tbss_pkg::ST_IDLE: begin
        if (in_valid) state_next = tbss_pkg::ST_TWEAK;
      end
      tbss_pkg::ST_TWEAK:   state_next = tbss_pkg::ST_MID;
      tbss_pkg::ST_MID:     state_next = tbss_pkg::ST_DRY;
      tbss_pkg::ST_DRY: begin
        band_next  = 1'b0;
        state_next = tbss_pkg::ST_LP_MUL;
      end
      tbss_pkg::ST_LP_MUL:  state_next = tbss_pkg::ST_LP_ACC;
      tbss_pkg::ST_LP_ACC:  state_next = tbss_pkg::ST_GL_MUL;
      tbss_pkg::ST_GL_MUL:  state_next = tbss_pkg::ST_GL_RND;
      tbss_pkg::ST_GL_RND: begin
        clip_high_next = 1'b0;
        state_next     = tbss_pkg::ST_CLIP_CHK;
      end
      tbss_pkg::ST_CLIP_CHK: begin
        state_next = status.clip_active ? tbss_pkg::ST_DIV_INIT : clip_ret;
      end
      tbss_pkg::ST_DIV_INIT: begin
        count_next = '0;
        state_next = tbss_pkg::ST_DIV_STEP;
      end
      tbss_pkg::ST_DIV_STEP: begin
        count_next = count + 1'b1;
        if (count == CNT_W'(tbss_pkg::DIV_STEPS - 1)) state_next = tbss_pkg::ST_SIN_IDX;
      end
      tbss_pkg::ST_SIN_IDX: state_next = tbss_pkg::ST_SIN_RD;
      tbss_pkg::ST_SIN_RD:  state_next = tbss_pkg::ST_SIN_MUL;
      tbss_pkg::ST_SIN_MUL: state_next = tbss_pkg::ST_SIN_INT;
      tbss_pkg::ST_SIN_INT: state_next = tbss_pkg::ST_SCL_MUL;
      tbss_pkg::ST_SCL_MUL: state_next = tbss_pkg::ST_SCL;
      tbss_pkg::ST_SCL:     state_next = clip_ret;
      tbss_pkg::ST_LOW_SAVE: state_next = tbss_pkg::ST_GH_RND;
      tbss_pkg::ST_GH_RND: begin
        clip_high_next = 1'b1;
        state_next     = tbss_pkg::ST_CLIP_CHK;
      end
      tbss_pkg::ST_MIX_L:   state_next = tbss_pkg::ST_MIX_H;
      tbss_pkg::ST_MIX_H:   state_next = tbss_pkg::ST_MIX_OUT;
      tbss_pkg::ST_MIX_OUT: state_next = tbss_pkg::ST_DEC_A;
      tbss_pkg::ST_DEC_A:   state_next = tbss_pkg::ST_DEC_B;
      tbss_pkg::ST_DEC_B:   state_next = tbss_pkg::ST_DEC_OM;
      tbss_pkg::ST_DEC_OM:  state_next = tbss_pkg::ST_DEC_O;
      tbss_pkg::ST_DEC_O: begin
        if (band) begin
          state_next = tbss_pkg::ST_TRIM;
        end else begin
          band_next  = 1'b1;
          state_next = tbss_pkg::ST_LP_MUL;
        end
      end
      tbss_pkg::ST_TRIM:    state_next = tbss_pkg::ST_OUT;
      tbss_pkg::ST_OUT: begin
        if (out_load) state_next = tbss_pkg::ST_IDLE;
      end
      default:              state_next = tbss_pkg::ST_IDLE;
    endcase
  end

  // Output beat holds until taken.
  always_comb begin
    out_valid_next = out_valid;
    if (out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  assign cmd.step      = state;
  assign cmd.load      = in_ready && in_valid;
  assign cmd.band      = band;
  assign cmd.clip_high = clip_high;
  assign cmd.out_load  = out_load;

endmodule

// ----- rtl/core/tbss_datapath.sv -----
module tbss_datapath #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [tbss_pkg::INDEX_W-1:0]        wr_index,
  input  logic [tbss_pkg::WDATA_W-1:0]        wr_data,
  input  logic signed [tbss_pkg::SAMPLE_W-1:0] in_sample,
  output logic signed [tbss_pkg::SAMPLE_W-1:0] out_sample,
  input  tbss_pkg::cmd_t                      cmd,
  output tbss_pkg::status_t                   status
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 17 + IW;

  // Configuration registers.
  logic [24:0] lowpass_coeff;
  logic [23:0] gain_high, gain_low;
  logic [16:0] threshold_high, threshold_low;
  logic [17:0] mix_high, mix_low;
  logic [16:0] mix_dry;

  // Sample state.
  logic signed [23:0] x, past_in_one, past_in_two, past_in_three;
  logic signed [31:0] mid, lowpass_mid_acc, lowpass_raw_acc;
  logic signed [39:0] alias_acc_first, alias_acc_second;
  logic               alias_phase;

  // Working registers.
  logic signed [67:0] prod, sum;
  logic signed [40:0] cv, low;
  logic [40:0]        e;
  logic [29:0]        big_t;
  logic [16:0]        d;
  logic               neg, div_sat;
  logic [47:0]        den;
  logic [48:0]        rem;
  logic [16:0]        q;
  logic [IW-1:0]      idx0, idx1;
  logic [15:0]        frac;
  logic [24:0]        e0, e1;
  logic signed [25:0] s;
  logic signed [45:0] cd;
  logic signed [41:0] y;

  // Combinational terms.
  logic signed [41:0] ma;
  logic signed [25:0] mb;
  logic               mul_en;
  logic signed [31:0] v, acc;
  logic signed [32:0] vd;
  logic [24:0]        coeff;
  logic [16:0]        tc, d_now;
  logic [29:0]        big_t_now;
  logic [40:0]        mag;
  logic               over, hard;
  logic [48:0]        r2;
  logic [16:0]        u;
  logic [PW-1:0]      p;
  logic [IW:0]        ti;
  logic signed [24:0] xp;
  logic signed [68:0] mix_sum, dec_r, out_r;
  logic signed [46:0] dec_a, dec_b;
  logic signed [31:0] m_clip;
  logic [24:0]        sine_rom [SINE_TABLE_DEPTH+1];

  function automatic logic signed [68:0] rnd(input logic signed [68:0] val, input int sh);
    return (val + (69'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [46:0] val);
    if (val > 47'sh7F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
    if (val < -47'sh80_0000_0000) return -40'sh80_0000_0000;
    return val[39:0];
  endfunction

  // Quarter-wave sine table, built at elaboration.
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic [63:0] XK = (64'(k) << 30) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = tbss_pkg::sine_poly(XK);
  end

  // Band operands.
  assign v     = cmd.band ? 32'($signed({x, 6'b0})) : mid;
  assign acc   = cmd.band ? lowpass_raw_acc : lowpass_mid_acc;
  assign vd    = 33'(v) - 33'(acc);
  assign coeff = (lowpass_coeff > 25'(tbss_pkg::UNITY_Q24)) ? 25'(tbss_pkg::UNITY_Q24)
                                                            : lowpass_coeff;
  assign xp    = 25'(x) + 25'(past_in_one);

  // Clip knee terms for the band being clipped.
  assign tc        = (cmd.clip_high ? threshold_high : threshold_low) > 17'(tbss_pkg::UNITY_Q16)
                     ? 17'(tbss_pkg::UNITY_Q16)
                     : (cmd.clip_high ? threshold_high : threshold_low);
  assign d_now     = 17'(tbss_pkg::UNITY_Q16) - tc;
  assign big_t_now = {tc[16:0], 13'b0};
  assign mag       = cv[40] ? 41'(-cv) : 41'(cv);
  assign over      = mag > 41'(big_t_now);
  assign hard      = (tc == 17'(tbss_pkg::UNITY_Q16));
  assign status.clip_active = over && !hard;

  // Division, table index and rounding terms.
  assign r2      = {rem[47:0], 1'b0};
  assign u       = div_sat ? 17'(tbss_pkg::UNITY_Q16)
                 : (q > 17'(tbss_pkg::UNITY_Q16) ? 17'(tbss_pkg::UNITY_Q16) : q);
  assign p       = PW'(u) * PW'(SINE_TABLE_DEPTH);
  assign ti      = p[PW-1:16];
  assign mix_sum = 69'(sum) + 69'(prod);
  assign dec_r   = rnd(69'(prod), 24);
  assign dec_a   = 47'(dec_r) + (alias_phase ? 47'(cd) : -47'(cd));
  assign dec_b   = 47'(dec_r) + (alias_phase ? -47'(cd) : 47'(cd));
  assign out_r   = rnd(69'(prod), 21);
  assign m_clip  = 32'($signed({2'b0, big_t})) + 32'(rnd(69'(prod), 11));

  // Shared multiplier operand selection.
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b0;
    case (cmd.step)
      tbss_pkg::ST_TWEAK: begin
        ma = 42'(past_in_three) - 42'(past_in_two);
        mb = 26'(tbss_pkg::TWEAK_Q24);
        mul_en = 1'b1;
      end
      tbss_pkg::ST_MID: begin
        ma = 42'(x);
        mb = 26'($signed({1'b0, mix_dry}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_LP_MUL: begin
        ma = 42'(vd);
        mb = 26'($signed({1'b0, coeff}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_GL_MUL: begin
        ma = 42'(acc);
        mb = 26'($signed({1'b0, gain_low}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_LOW_SAVE: begin
        ma = 42'(vd);
        mb = 26'($signed({1'b0, gain_high}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_CLIP_CHK: begin
        ma = 42'(tbss_pkg::HALFPI_Q30);
        mb = 26'($signed({1'b0, d_now}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_SIN_MUL: begin
        ma = 42'($signed({1'b0, e1})) - 42'($signed({1'b0, e0}));
        mb = 26'($signed({1'b0, frac}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_SCL_MUL: begin
        ma = 42'(s);
        mb = 26'($signed({1'b0, d}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_MIX_L: begin
        ma = 42'(low);
        mb = 26'($signed({1'b0, mix_low}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_MIX_H: begin
        ma = 42'(cv);
        mb = 26'($signed({1'b0, mix_high}));
        mul_en = 1'b1;
      end
      tbss_pkg::ST_MIX_OUT: begin
        ma = 42'(alias_acc_first);
        mb = 26'(tbss_pkg::DECAY_Q24);
        mul_en = 1'b1;
      end
      tbss_pkg::ST_DEC_A: begin
        ma = 42'(alias_acc_second);
        mb = 26'(tbss_pkg::DECAY_Q24);
        mul_en = 1'b1;
      end
      tbss_pkg::ST_DEC_OM: begin
        ma = alias_phase ? 42'(alias_acc_first) : 42'(alias_acc_second);
        mb = 26'(tbss_pkg::DECAY_Q24);
        mul_en = 1'b1;
      end
      tbss_pkg::ST_TRIM: begin
        ma = y;
        mb = 26'(tbss_pkg::OUTPUT_TRIM);
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Configuration registers and sample state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowpass_coeff    <= '0;
      gain_high        <= 24'(tbss_pkg::UNITY_Q16);
      gain_low         <= 24'(tbss_pkg::UNITY_Q16);
      threshold_high   <= 17'(tbss_pkg::UNITY_Q16);
      threshold_low    <= 17'(tbss_pkg::UNITY_Q16);
      mix_high         <= 18'(tbss_pkg::UNITY_Q16);
      mix_low          <= 18'(tbss_pkg::UNITY_Q16);
      mix_dry          <= '0;
      past_in_one      <= '0;
      past_in_two      <= '0;
      past_in_three    <= '0;
      lowpass_mid_acc  <= '0;
      lowpass_raw_acc  <= '0;
      alias_acc_first  <= '0;
      alias_acc_second <= '0;
      alias_phase      <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (tbss_pkg::reg_idx_t'(wr_index))
          tbss_pkg::REG_LOWPASS_COEFF:  lowpass_coeff  <= wr_data[24:0];
          tbss_pkg::REG_GAIN_HIGH:      gain_high      <= wr_data[23:0];
          tbss_pkg::REG_GAIN_LOW:       gain_low       <= wr_data[23:0];
          tbss_pkg::REG_THRESHOLD_HIGH: threshold_high <= wr_data[16:0];
          tbss_pkg::REG_THRESHOLD_LOW:  threshold_low  <= wr_data[16:0];
          tbss_pkg::REG_MIX_HIGH:       mix_high       <= wr_data[17:0];
          tbss_pkg::REG_MIX_LOW:        mix_low        <= wr_data[17:0];
          tbss_pkg::REG_MIX_DRY:        mix_dry        <= wr_data[16:0];
          default: ;
        endcase
      end
      case (cmd.step)
        tbss_pkg::ST_MID: begin
          past_in_three <= past_in_two;
          past_in_two   <= past_in_one;
          past_in_one   <= x;
        end
        tbss_pkg::ST_LP_ACC: begin
          if (cmd.band) lowpass_raw_acc <= acc + 32'(rnd(69'(prod), 24));
          else lowpass_mid_acc <= acc + 32'(rnd(69'(prod), 24));
        end
        tbss_pkg::ST_DEC_A: begin
          alias_acc_first <= sat40(dec_a);
        end
        tbss_pkg::ST_DEC_B: begin
          alias_acc_second <= sat40(dec_b);
        end
        tbss_pkg::ST_TRIM: begin
          alias_phase <= !alias_phase;
        end
        default: ;
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (mul_en) prod <= ma * mb;
    if (cmd.load) x <= in_sample;
    if (cmd.out_load) begin
      if (out_r > 69'sd8388607) out_sample <= 24'sh7F_FFFF;
      else if (out_r < -69'sd8388608) out_sample <= -24'sh80_0000;
      else out_sample <= out_r[23:0];
    end
    case (cmd.step)
      tbss_pkg::ST_MID: begin
        mid <= 32'(rnd((69'(xp) <<< 24) + 69'(prod), 19));
      end
      tbss_pkg::ST_DRY: begin
        y <= 42'(rnd(69'(prod), 10));
      end
      tbss_pkg::ST_GL_RND, tbss_pkg::ST_GH_RND: begin
        cv <= 41'(rnd(69'(prod), 16));
      end
      tbss_pkg::ST_CLIP_CHK: begin
        big_t <= big_t_now;
        neg   <= cv[40];
        e     <= mag - 41'(big_t_now);
        d     <= d_now;
        if (over && hard) cv <= cv[40] ? -41'(big_t_now) : 41'(big_t_now);
      end
      tbss_pkg::ST_DIV_INIT: begin
        den     <= prod[47:0];
        div_sat <= e >= 41'(prod[47:17]);
        rem     <= (e >= 41'(prod[47:17])) ? '0 : {e[32:0], 16'b0};
        q       <= '0;
      end
      tbss_pkg::ST_DIV_STEP: begin
        if (r2 >= {1'b0, den}) begin
          rem <= r2 - {1'b0, den};
          q   <= {q[15:0], 1'b1};
        end else begin
          rem <= r2;
          q   <= {q[15:0], 1'b0};
        end
      end
      tbss_pkg::ST_SIN_IDX: begin
        if (ti >= (IW+1)'(SINE_TABLE_DEPTH)) begin
          idx0 <= IW'(SINE_TABLE_DEPTH);
          idx1 <= IW'(SINE_TABLE_DEPTH);
          frac <= '0;
        end else begin
          idx0 <= ti[IW-1:0];
          idx1 <= IW'(ti + 1'b1);
          frac <= p[15:0];
        end
      end
      tbss_pkg::ST_SIN_RD: begin
        e0 <= sine_rom[idx0];
        e1 <= sine_rom[idx1];
      end
      tbss_pkg::ST_SIN_INT: begin
        s <= 26'($signed({1'b0, e0})) + 26'(rnd(69'(prod), 16));
      end
      tbss_pkg::ST_SCL: begin
        cv <= neg ? -41'(m_clip) : 41'(m_clip);
      end
      tbss_pkg::ST_LOW_SAVE: begin
        low <= cv;
      end
      tbss_pkg::ST_MIX_H: begin
        sum <= prod;
      end
      tbss_pkg::ST_MIX_OUT: begin
        cd <= 46'(rnd(mix_sum, 16)) - 46'(v);
      end
      tbss_pkg::ST_DEC_O: begin
        y <= y + 42'(dec_r);
      end
      default: ;
    endcase
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

  typedef logic signed [tbss_pkg::SAMPLE_W-1:0] sample_t;

  localparam longint ACC40_TOP = 64'sd549755813887;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 160;
  localparam int HOLDOFF_LEN = 500;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [tbss_pkg::INDEX_W-1:0] wr_index;
  logic [tbss_pkg::WDATA_W-1:0] wr_data;

  tbss_in_if audio ();
  tbss_out_if result ();

  two_band_sine_saturator dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .audio(audio.sink),
    .result(result.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file.
  longint cfg_coeff, cfg_gain_hi, cfg_gain_lo, cfg_thr_hi, cfg_thr_lo;
  longint cfg_mix_hi, cfg_mix_lo, cfg_mix_dry;
  // Shadow copy of the signal state.
  longint prev1, prev2, prev3, lp_mid, lp_raw, alias_a, alias_b;
  bit alias_odd;

  sample_t expected_out[$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_epoch = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  function automatic longint rnd(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat40(input longint v);
    if (v > ACC40_TOP) return ACC40_TOP;
    if (v < -ACC40_TOP - 1) return -ACC40_TOP - 1;
    return v;
  endfunction

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // One quarter-wave table point, Q0.24, from the odd polynomial.
  function automatic longint quarter_sine_point(input int k);
    longint unsigned x, x2, t, s;
    x = (longint'(k) << 30) / 256;
    x2 = q30_mul(x, x);
    t = 64'd172272 - q30_mul(x2, 64'd3864);
    t = 64'd5026996 - q30_mul(x2, t);
    t = 64'd85569310 - q30_mul(x2, t);
    t = 64'd693598668 - q30_mul(x2, t);
    t = 64'd1686629713 - q30_mul(x2, t);
    s = (q30_mul(x, t) + 64'd32) >> 6;
    if (s > 64'd16777216) s = 64'd16777216;
    return longint'(s);
  endfunction

  function automatic longint sine_interp(input longint u);
    longint p, i, f, e0, e1;
    p = u * 256;
    i = p >> 16;
    f = p & 65535;
    if (i >= 256) return quarter_sine_point(256);
    e0 = quarter_sine_point(int'(i));
    e1 = quarter_sine_point(int'(i) + 1);
    return e0 + rnd((e1 - e0) * f, 16);
  endfunction

  // Sine knee above the threshold; a full-scale threshold is a hard clip.
  function automatic longint knee_clip(input longint v, input longint thr);
    longint t, big_t, mag, m, u;
    longint unsigned d, den, e;
    t = (thr > 65536) ? 65536 : thr;
    big_t = t * 8192;
    mag = (v < 0) ? -v : v;
    if (mag <= big_t) return v;
    if (t == 65536) begin
      m = big_t;
    end else begin
      d = 65536 - t;
      den = d * 64'd1686629713;
      e = mag - big_t;
      if (e >= (den >> 17)) u = 65536;
      else u = longint'((e << 33) / den);
      if (u > 65536) u = 65536;
      m = big_t + rnd(sine_interp(u) * longint'(d), 11);
    end
    return (v > 0) ? m : -m;
  endfunction

  function automatic longint band_mix(input longint v, inout longint acc);
    longint c, lo, hi;
    c = (cfg_coeff > 16777216) ? 16777216 : cfg_coeff;
    acc = acc + rnd((v - acc) * c, 24);
    lo = knee_clip(rnd(acc * cfg_gain_lo, 16), cfg_thr_lo);
    hi = knee_clip(rnd((v - acc) * cfg_gain_hi, 16), cfg_thr_hi);
    return rnd(lo * cfg_mix_lo + hi * cfg_mix_hi, 16);
  endfunction

  function automatic longint shrink(input longint a);
    return rnd(a * tbss_pkg::DECAY_Q24, 24);
  endfunction

  // Alternating decaying pair; the phase picks which side takes the difference.
  function automatic longint alias_update(input longint c);
    longint o;
    if (alias_odd) begin
      alias_a = sat40(shrink(alias_a) + c);
      alias_b = sat40(shrink(alias_b) - c);
      o = alias_a;
    end else begin
      alias_b = sat40(shrink(alias_b) + c);
      alias_a = sat40(shrink(alias_a) - c);
      o = alias_b;
    end
    return shrink(o);
  endfunction

  function automatic sample_t process_sample(input sample_t xin);
    longint x, mid, dry, mid_wet, raw_wet, mid_diff, raw_diff, y;
    x = xin;
    mid = rnd((x + prev1) * 64'sd16777216 + (prev3 - prev2) * tbss_pkg::TWEAK_Q24, 19);
    prev3 = prev2;
    prev2 = prev1;
    prev1 = x;
    dry = x * 64;
    mid_wet = band_mix(mid, lp_mid);
    raw_wet = band_mix(dry, lp_raw);
    mid_diff = alias_update(mid_wet - mid);
    raw_diff = alias_update(raw_wet - dry);
    alias_odd = !alias_odd;
    y = rnd(x * cfg_mix_dry, 10) + raw_diff + mid_diff;
    y = rnd(y * tbss_pkg::OUTPUT_TRIM, 21);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return sample_t'(y);
  endfunction

  // Register write; the shadow copy keeps only the register's width.
  task automatic write_reg(input tbss_pkg::reg_idx_t idx, input longint val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val[tbss_pkg::WDATA_W-1:0];
    case (idx)
      tbss_pkg::REG_LOWPASS_COEFF: cfg_coeff = val & 64'h1FFFFFF;
      tbss_pkg::REG_GAIN_HIGH: cfg_gain_hi = val & 64'hFFFFFF;
      tbss_pkg::REG_GAIN_LOW: cfg_gain_lo = val & 64'hFFFFFF;
      tbss_pkg::REG_THRESHOLD_HIGH: cfg_thr_hi = val & 64'h1FFFF;
      tbss_pkg::REG_THRESHOLD_LOW: cfg_thr_lo = val & 64'h1FFFF;
      tbss_pkg::REG_MIX_HIGH: cfg_mix_hi = val & 64'h3FFFF;
      tbss_pkg::REG_MIX_LOW: cfg_mix_lo = val & 64'h3FFFF;
      tbss_pkg::REG_MIX_DRY: cfg_mix_dry = val & 64'h1FFFF;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic write_all(input longint c, input longint gh, input longint gl,
                           input longint th, input longint tl, input longint mh,
                           input longint ml, input longint md);
    write_reg(tbss_pkg::REG_LOWPASS_COEFF, c);
    write_reg(tbss_pkg::REG_GAIN_HIGH, gh);
    write_reg(tbss_pkg::REG_GAIN_LOW, gl);
    write_reg(tbss_pkg::REG_THRESHOLD_HIGH, th);
    write_reg(tbss_pkg::REG_THRESHOLD_LOW, tl);
    write_reg(tbss_pkg::REG_MIX_HIGH, mh);
    write_reg(tbss_pkg::REG_MIX_LOW, ml);
    write_reg(tbss_pkg::REG_MIX_DRY, md);
  endtask

  // Send one sample beat; valid stays high into the next call unless a gap falls.
  task automatic send_sample(input sample_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      audio.valid <= 1'b0;
      @(negedge clk);
    end
    audio.valid <= 1'b1;
    audio.in_sample <= x;
    @(posedge clk);
    while (!audio.ready) @(posedge clk);
    expected_out.push_back(process_sample(x));
    @(negedge clk);
  endtask

  // Stop sending and let every pending beat come out before a register write.
  task automatic drain;
    audio.valid <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic sample_t rand_sample;
    case ($urandom_range(4))
      0: return sample_t'($signed($urandom_range(1000)) - 500);
      1: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
      2: return $urandom_range(1) ? sample_t'($urandom_range(8388607, 6000000))
                                  : sample_t'(-$signed($urandom_range(8388608, 6000000)));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic longint rand_reg(input int hi_bits, input longint lo,
                                      input longint hi);
    if ($urandom_range(9) == 0) return $urandom & ((64'd1 << hi_bits) - 1);
    return lo + ($urandom % (hi - lo + 1));
  endfunction

  task automatic set_phase(input int p);
    case (p % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 59; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 59; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // Field extremes and sign patterns under the reset settings (hard knee).
  task automatic test_directed_extremes;
    sample_t pats[12];
    pats = '{0, 1, -1, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000,
             24'sh555555, -24'sh555556, 24'sh400000, 0, 24'sh000100};
    set_phase(0);
    foreach (pats[i]) send_sample(pats[i]);
    drain();
  endtask

  // Soft knees, coefficient and thresholds above range, full drive.
  task automatic test_special_settings;
    write_all(64'd16777216, 64'd16462000, 64'd16462000, 64'd0, 64'd30000,
              64'd170197, 64'd170197, 64'd101608);
    for (int i = 0; i < 10; i++) send_sample(i[0] ? 24'sh7FFFFF : -24'sh800000);
    drain();
    write_all(64'h1FFFFFF, 64'hFFFFFF, 64'd65536, 64'h1FFFF, 64'd65535,
              64'h3FFFF, 64'd0, 64'h1FFFF);
    for (int i = 0; i < 8; i++) send_sample(rand_sample());
    drain();
  endtask

  // Output held off long enough that the block fills and stalls its input.
  task automatic test_output_backpressure;
    set_phase(0);
    holdoff_epoch = holdoff_epoch + 1;
    for (int i = 0; i < 12; i++) send_sample(rand_sample());
    drain();
  endtask

  // Several register settings, extremes among them, under every idling phase.
  task automatic test_random_settings;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: write_all(0, 65536, 65536, 0, 0, 0, 0, 0);
        1: write_all(16777216, 16462000, 65536, 65536, 0, 170197, 170197, 101608);
        2: write_all(1, 65536, 16462000, 32768, 65536, 65536, 170197, 0);
        default: write_all(rand_reg(25, 0, 16777216), rand_reg(24, 65536, 16462000),
                           rand_reg(24, 65536, 16462000), rand_reg(17, 0, 65536),
                           rand_reg(17, 0, 65536), rand_reg(18, 0, 170197),
                           rand_reg(18, 0, 170197), rand_reg(17, 0, 101608));
      endcase
      set_phase(s);
      for (int i = 0; i < 130; i++) begin
        if (i == 65) set_phase(s + 1);
        send_sample(rand_sample());
      end
      drain();
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when a new one is requested.
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_epoch) begin
      holdoff_seen = holdoff_epoch;
      holdoff_left = HOLDOFF_LEN;
    end
    if (holdoff_left > 0) begin
      result.ready <= 1'b0;
      holdoff_left = holdoff_left - 1;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each output beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (expected_out.size() == 0) begin
        $error("out_sample beat with no prediction pending, actual %0d",
               result.out_sample);
        failures++;
      end else begin
        if (result.out_sample !== expected_out[0]) begin
          $error("out_sample expected %0d actual %0d", expected_out[0],
                 result.out_sample);
          failures++;
        end
        void'(expected_out.pop_front());
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if ((audio.valid && audio.ready) || (result.valid && result.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    audio.valid = 1'b0;
    audio.in_sample = '0;
    cfg_coeff = 0; cfg_gain_hi = 65536; cfg_gain_lo = 65536;
    cfg_thr_hi = 65536; cfg_thr_lo = 65536;
    cfg_mix_hi = 65536; cfg_mix_lo = 65536; cfg_mix_dry = 0;
    prev1 = 0; prev2 = 0; prev3 = 0; lp_mid = 0; lp_raw = 0;
    alias_a = 0; alias_b = 0; alias_odd = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_special_settings();
    test_output_backpressure();
    test_random_settings();

    while (expected_out.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- two_band_sine_saturator.f -----
rtl/core/tbss_pkg.sv
rtl/core/tbss_in_if.sv
rtl/core/tbss_out_if.sv
rtl/core/tbss_ctrl.sv
rtl/core/tbss_datapath.sv
rtl/core/two_band_sine_saturator.sv
sim/tb_top.sv
